>>> hdl/bpnc_pkg.sv
package bpnc_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int FRAC_BITS_DEF = 16;

    // ln(2) in Q28 and ln(2*pi) in Q32
    localparam logic [27:0] LN2_Q28    = 28'd186065280;
    localparam logic [32:0] LN_2PI_Q32 = 33'd7893621895;

    typedef enum logic [1:0] {
        OP_TIP      = 2'd0,
        OP_INTERNAL = 2'd1,
        OP_ROOT     = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        DIV_MEAN = 2'd0,
        DIV_VAR  = 2'd1,
        DIV_SQ   = 2'd2
    } div_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_R,
        ST_RD_L,
        ST_LAT_L,
        ST_SUM,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_MUL_D,
        ST_NUM,
        ST_DM_GO,
        ST_DM_WAIT,
        ST_DV_GO,
        ST_DV_WAIT,
        ST_DQ_GO,
        ST_DQ_WAIT,
        ST_LOG_WAIT,
        ST_LT,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQR,
        LG_MULF,
        LG_SUMS
    } log_phase_t;

    typedef struct packed {
        logic     capture;
        logic     rd_left;
        logic     lat_right;
        logic     lat_left;
        logic     sum;
        logic     mul_a;
        logic     mul_b;
        logic     mul_c;
        logic     mul_d;
        logic     num;
        logic     log_start;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_mean;
        logic     take_var;
        logic     take_sq;
        logic     fin_lt;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       zero_sum;
        logic       div_done;
        logic       log_done;
        logic       out_free;
    } sts_t;

endpackage

>>> hdl/bpnc_div.sv
module bpnc_div
    import bpnc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [33:0] divisor,
    output logic        busy,
    output logic [31:0] quotient,
    output logic        overflow
);

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] low_reg, low_next;
    logic [33:0] div_reg, div_next;
    logic        ovf_reg, ovf_next;
    logic [34:0] trial;
    logic        ge;

    always_comb
    begin
        trial     = {rem_reg, low_reg[31]};
        ge        = trial >= {1'b0, div_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        div_next  = div_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            // upper half below the divisor leaves a 32-bit quotient
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {2'b00, dividend[63:32]};
            low_next  = dividend[31:0];
            div_next  = divisor;
            ovf_next  = {2'b00, dividend[63:32]} >= divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 34'(trial - {1'b0, div_reg}) : trial[33:0];
            low_next = {low_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        div_reg <= div_next;
        ovf_reg <= ovf_next;
    end

    assign busy     = busy_reg;
    assign quotient = low_reg;
    assign overflow = ovf_reg;

endmodule

>>> hdl/bpnc_log.sv
module bpnc_log
    import bpnc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [32:0]        value,
    output logic               busy,
    output logic signed [31:0] half_ln
);

    log_phase_t         phase_reg, phase_next;
    logic [32:0]        x_reg, x_next;
    logic [5:0]         sh_reg, sh_next;
    logic [28:0]        mant_reg, mant_next;
    logic [27:0]        frac_reg, frac_next;
    logic [4:0]         k_reg, k_next;
    logic [55:0]        prod_reg, prod_next;
    logic signed [31:0] half_reg, half_next;
    logic [57:0]        sq;
    logic [29:0]        sq_hi;
    logic [5:0]         e;
    logic signed [7:0]  ef;
    logic signed [36:0] efm;
    logic signed [63:0] s;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            LG_IDLE: if (start) phase_next = LG_NORM;
            LG_NORM: if (x_reg[32]) phase_next = LG_SQR;
            LG_SQR:  if (k_reg == 5'd27) phase_next = LG_MULF;
            LG_MULF: phase_next = LG_SUMS;
            LG_SUMS: phase_next = LG_IDLE;
            default: phase_next = LG_IDLE;
        endcase
    end

    always_comb
    begin
        sq        = {29'd0, mant_reg} * {29'd0, mant_reg};
        sq_hi     = sq[57:28];
        e         = 6'd32 - sh_reg;
        ef        = $signed({2'b00, e}) - 8'(FRAC_BITS);
        efm       = ef * $signed({1'b0, LN2_Q28});
        s         = (64'(efm) <<< 28) + $signed({8'd0, prod_reg})
                    + $signed({7'd0, LN_2PI_Q32, 24'd0});
        x_next    = x_reg;
        sh_next   = sh_reg;
        mant_next = mant_reg;
        frac_next = frac_reg;
        k_next    = k_reg;
        prod_next = prod_reg;
        half_next = half_reg;
        case (phase_reg)
            LG_IDLE:
            begin
                if (start)
                begin
                    x_next  = value;
                    sh_next = '0;
                end
            end
            LG_NORM:
            begin
                if (x_reg[32])
                begin
                    mant_next = x_reg[32:4];
                    frac_next = '0;
                    k_next    = '0;
                end
                else
                begin
                    x_next  = {x_reg[31:0], 1'b0};
                    sh_next = sh_reg + 6'd1;
                end
            end
            LG_SQR:
            begin
                // square and pull one fraction bit per step
                if (sq_hi[29])
                begin
                    mant_next = sq_hi[29:1];
                    frac_next = {frac_reg[26:0], 1'b1};
                end
                else
                begin
                    mant_next = sq_hi[28:0];
                    frac_next = {frac_reg[26:0], 1'b0};
                end
                k_next = k_reg + 5'd1;
            end
            LG_MULF:
            begin
                prod_next = {28'd0, frac_reg} * {28'd0, LN2_Q28};
            end
            LG_SUMS:
            begin
                half_next = 32'(s >>> (57 - FRAC_BITS));
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= LG_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        sh_reg   <= sh_next;
        mant_reg <= mant_next;
        frac_reg <= frac_next;
        k_reg    <= k_next;
        prod_reg <= prod_next;
        half_reg <= half_next;
    end

    assign busy    = (phase_reg != LG_IDLE);
    assign half_ln = half_reg;

endmodule

>>> hdl/bpnc_ctrl.sv
module bpnc_ctrl
    import bpnc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic request_valid,
    output logic request_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (request_valid) state_next = ST_RD_R;
            ST_RD_R:     state_next = (sts.op == OP_TIP) ? ST_FIN : ST_RD_L;
            ST_RD_L:     state_next = ST_LAT_L;
            ST_LAT_L:    state_next = ST_SUM;
            ST_SUM:      state_next = sts.zero_sum ? ST_FIN : ST_MUL_A;
            ST_MUL_A:    state_next = ST_MUL_B;
            ST_MUL_B:    state_next = ST_MUL_C;
            ST_MUL_C:    state_next = ST_MUL_D;
            ST_MUL_D:    state_next = ST_NUM;
            ST_NUM:      state_next = ST_DM_GO;
            ST_DM_GO:    state_next = ST_DM_WAIT;
            ST_DM_WAIT:  if (sts.div_done) state_next = ST_DV_GO;
            ST_DV_GO:    state_next = ST_DV_WAIT;
            ST_DV_WAIT:  if (sts.div_done) state_next = ST_DQ_GO;
            ST_DQ_GO:    state_next = ST_DQ_WAIT;
            ST_DQ_WAIT:  if (sts.div_done) state_next = ST_LOG_WAIT;
            ST_LOG_WAIT: if (sts.log_done) state_next = ST_LT;
            ST_LT:       state_next = ST_FIN;
            ST_FIN:      if (sts.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        request_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                request_ready = 1'b1;
                cmd.capture   = request_valid;
            end
            ST_RD_L:     cmd.rd_left   = 1'b1;
            ST_LAT_L:
            begin
                cmd.rd_left   = 1'b1;
                cmd.lat_left  = 1'b1;
            end
            ST_SUM:      cmd.sum = 1'b1;
            ST_MUL_A:
            begin
                cmd.mul_a     = 1'b1;
                cmd.log_start = 1'b1;
            end
            ST_MUL_B:    cmd.mul_b = 1'b1;
            ST_MUL_C:    cmd.mul_c = 1'b1;
            ST_MUL_D:    cmd.mul_d = 1'b1;
            ST_NUM:      cmd.num = 1'b1;
            ST_DM_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
            end
            ST_DM_WAIT:  cmd.take_mean = sts.div_done;
            ST_DV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_VAR;
            end
            ST_DV_WAIT:  cmd.take_var = sts.div_done;
            ST_DQ_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SQ;
            end
            ST_DQ_WAIT:  cmd.take_sq = sts.div_done;
            ST_LT:       cmd.fin_lt = 1'b1;
            ST_FIN:      cmd.load_out = sts.out_free;
            default:     cmd = '0;
        endcase
        // right child data arrives in the cycle after its read
        if (state_reg == ST_RD_L)
        begin
            cmd.lat_right = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/bpnc_dp.sv
module bpnc_dp
    import bpnc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [1:0]         operation,
    input  logic [9:0]         node_index,
    input  logic [9:0]         right_child,
    input  logic [9:0]         left_child,
    input  logic signed [31:0] tip_value,
    input  logic [30:0]        tip_variance,
    input  logic [30:0]        branch_length,
    input  logic [30:0]        branch_rate,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [9:0]         out_node,
    output logic signed [31:0] init_mean,
    output logic [30:0]        init_variance,
    output logic signed [31:0] base_mean,
    output logic [30:0]        base_variance,
    output logic signed [31:0] log_term,
    output logic               zero_variance_error
);

    localparam int AW  = $clog2(MAX_NODES);
    localparam int BRW = 62 - FRAC_BITS;
    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    function automatic logic [AW-1:0] slot(input logic [9:0] idx);
        int unsigned r;
        int unsigned lim;
        r = 32'(idx);
        for (int k = 9; k >= 0; k--)
        begin
            lim = 32'(MAX_NODES) << k;
            if (r >= lim)
            begin
                r = r - lim;
            end
        end
        return AW'(r);
    endfunction

    logic [1:0]         op_reg;
    logic [AW-1:0]      node_reg, rc_reg, lc_reg;
    logic signed [31:0] tipv_reg;
    logic [30:0]        tvar_reg, blen_reg, brate_reg;
    logic [61:0]        bprod;
    logic [BRW-1:0]     branch_reg;

    logic [62:0]        mem [MAX_NODES];
    logic [62:0]        rdata_reg;
    logic [AW-1:0]      raddr;
    logic               we;
    logic [62:0]        wdata;

    logic signed [31:0] m1_reg, m2_reg;
    logic [30:0]        v1_reg, v2_reg;
    logic [32:0]        v12_reg;
    logic [31:0]        ad_reg;
    logic               zero_reg;
    logic signed [32:0] dm;
    logic signed [63:0] p1_reg, p2_reg, num_reg;
    logic [61:0]        pv_reg;
    logic [63:0]        sq_reg;

    logic [63:0]        div_dividend;
    logic [33:0]        div_divisor;
    logic               div_busy, div_ovf;
    logic [31:0]        quot;
    logic               log_busy;
    logic signed [31:0] half_ln;

    logic signed [31:0] init_m_reg;
    logic [30:0]        init_v_reg;
    logic [32:0]        q_reg;
    logic signed [31:0] lt_reg;
    logic signed [34:0] lt_wide;

    logic signed [31:0] r_init_m, r_base_m, r_lt;
    logic [30:0]        r_init_v, r_base_v;
    logic               r_err;
    logic [BRW:0]       bsum;

    logic               out_valid_reg, out_valid_next;
    logic [9:0]         o_node_reg;
    logic signed [31:0] o_init_m_reg, o_base_m_reg, o_lt_reg;
    logic [30:0]        o_init_v_reg, o_base_v_reg;
    logic               o_err_reg;

    // capture the request and derive the branch term
    assign bprod = {31'd0, blen_reg} * {31'd0, brate_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            node_reg  <= slot(node_index);
            rc_reg    <= slot(right_child);
            lc_reg    <= slot(left_child);
            tipv_reg  <= tip_value;
            tvar_reg  <= tip_variance;
            blen_reg  <= branch_length;
            brate_reg <= branch_rate;
        end
        branch_reg <= bprod[61:FRAC_BITS];
    end

    // node store
    assign raddr = cmd.rd_left ? lc_reg : rc_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[node_reg] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign dm = 33'(m1_reg) - 33'(m2_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.lat_right)
        begin
            m1_reg <= rdata_reg[62:31];
            v1_reg <= rdata_reg[30:0];
        end
        if (cmd.lat_left)
        begin
            m2_reg <= rdata_reg[62:31];
            v2_reg <= rdata_reg[30:0];
        end
        if (cmd.sum)
        begin
            v12_reg  <= {2'b00, v1_reg} + {2'b00, v2_reg};
            ad_reg   <= dm[32] ? 32'(-dm) : dm[31:0];
            zero_reg <= (v1_reg == '0) && (v2_reg == '0);
        end
        if (cmd.mul_a)
        begin
            p1_reg <= 64'(m1_reg) * 64'($signed({1'b0, v2_reg}));
        end
        if (cmd.mul_b)
        begin
            p2_reg <= 64'(m2_reg) * 64'($signed({1'b0, v1_reg}));
        end
        if (cmd.mul_c)
        begin
            pv_reg <= {31'd0, v1_reg} * {31'd0, v2_reg};
        end
        if (cmd.mul_d)
        begin
            sq_reg <= {32'd0, ad_reg} * {32'd0, ad_reg};
        end
        if (cmd.num)
        begin
            num_reg <= p1_reg + p2_reg;
        end
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_MEAN:
            begin
                div_dividend = num_reg[63] ? 64'(-num_reg) : num_reg;
                div_divisor  = {1'b0, v12_reg};
            end
            DIV_VAR:
            begin
                div_dividend = {2'b00, pv_reg};
                div_divisor  = {1'b0, v12_reg};
            end
            DIV_SQ:
            begin
                div_dividend = sq_reg;
                div_divisor  = {v12_reg, 1'b0};
            end
            default:
            begin
                div_dividend = sq_reg;
                div_divisor  = {v12_reg, 1'b0};
            end
        endcase
    end

    bpnc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quot),
        .overflow (div_ovf)
    );

    bpnc_log #(
        .FRAC_BITS (FRAC_BITS)
    ) u_log (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.log_start),
        .value   (v12_reg),
        .busy    (log_busy),
        .half_ln (half_ln)
    );

    assign lt_wide = -$signed({2'b00, q_reg}) - 35'(half_ln);

    always_ff @(posedge clk)
    begin
        if (cmd.take_mean)
        begin
            init_m_reg <= num_reg[63] ? -quot : quot;
        end
        if (cmd.take_var)
        begin
            init_v_reg <= quot[30:0];
        end
        if (cmd.take_sq)
        begin
            // cap the squared-difference quotient at 2^32
            q_reg <= div_ovf ? {1'b1, 32'd0} : {1'b0, quot};
        end
        if (cmd.fin_lt)
        begin
            if (lt_wide > 35'sh0_7FFF_FFFF)
            begin
                lt_reg <= 32'sh7FFF_FFFF;
            end
            else if (lt_wide < -35'sh0_8000_0000)
            begin
                lt_reg <= 32'sh8000_0000;
            end
            else
            begin
                lt_reg <= lt_wide[31:0];
            end
        end
    end

    // result assembly
    always_comb
    begin
        r_err    = 1'b0;
        r_init_m = '0;
        r_init_v = '0;
        r_lt     = '0;
        r_base_m = '0;
        r_base_v = '0;
        bsum     = '0;
        we       = 1'b0;
        case (op_reg)
            OP_TIP:
            begin
                r_init_m = tipv_reg;
                r_base_m = tipv_reg;
                bsum     = (BRW+1)'(tvar_reg) + (BRW+1)'(branch_reg);
                r_base_v = (bsum > (BRW+1)'(MAX31)) ? MAX31 : bsum[30:0];
                we       = cmd.load_out;
            end
            OP_INTERNAL:
            begin
                r_err = zero_reg;
                if (!zero_reg)
                begin
                    r_init_m = init_m_reg;
                    r_init_v = init_v_reg;
                    r_lt     = lt_reg;
                end
                r_base_m = r_init_m;
                bsum     = (BRW+1)'(r_init_v) + (BRW+1)'(branch_reg);
                r_base_v = (bsum > (BRW+1)'(MAX31)) ? MAX31 : bsum[30:0];
                we       = cmd.load_out;
            end
            default:
            begin
                // root: report only
                r_err = zero_reg;
                if (!zero_reg)
                begin
                    r_init_m = init_m_reg;
                    r_init_v = init_v_reg;
                    r_lt     = lt_reg;
                end
            end
        endcase
    end

    assign wdata = {r_base_m, r_base_v};

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            o_node_reg   <= 10'(node_reg);
            o_init_m_reg <= r_init_m;
            o_init_v_reg <= r_init_v;
            o_base_m_reg <= r_base_m;
            o_base_v_reg <= r_base_v;
            o_lt_reg     <= r_lt;
            o_err_reg    <= r_err;
        end
    end

    assign sts.op       = op_reg;
    assign sts.zero_sum = (v1_reg == '0) && (v2_reg == '0);
    assign sts.div_done = !div_busy;
    assign sts.log_done = !log_busy;
    assign sts.out_free = !out_valid_reg || result_ready;

    assign result_valid        = out_valid_reg;
    assign out_node            = o_node_reg;
    assign init_mean           = o_init_m_reg;
    assign init_variance       = o_init_v_reg;
    assign base_mean           = o_base_m_reg;
    assign base_variance       = o_base_v_reg;
    assign log_term            = o_lt_reg;
    assign zero_variance_error = o_err_reg;

endmodule

>>> hdl/brownian_pruning_node_combine.sv
// Brownian-motion pruning step in signed fixed point (FRAC_BITS fraction bits).
// Send nodes in postorder, one request per node; each request gives one result.
// A tip goes straight from its read state to the output load. An internal or root
// combine reads the node store (ST_RD_R, ST_RD_L, ST_LAT_L), then has a sum state,
// the multiply states ST_MUL_A to ST_MUL_D and a numerator state (ST_NUM). Then
// come three 32-step divisions on one shared divider that retires one quotient
// bit per cycle. Last it waits on the logarithm unit, clamps the log term and
// loads the output. The logarithm unit runs alongside the divider. A zero
// variance sum skips to the output after the sum cycle. A result held by the
// consumer delays the load of the next one. One request is in flight at a time;
// a finished result waits in the output register while the next request is taken.
// The node store is not cleared at reset; combine only children already sent.
module brownian_pruning_node_combine
    import bpnc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_ready,
    input  logic [1:0]         operation,
    input  logic [9:0]         node_index,
    input  logic [9:0]         right_child,
    input  logic [9:0]         left_child,
    input  logic signed [31:0] tip_value,
    input  logic [30:0]        tip_variance,
    input  logic [30:0]        branch_length,
    input  logic [30:0]        branch_rate,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [9:0]         out_node,
    output logic signed [31:0] init_mean,
    output logic [30:0]        init_variance,
    output logic signed [31:0] base_mean,
    output logic [30:0]        base_variance,
    output logic signed [31:0] log_term,
    output logic               zero_variance_error
);

    cmd_t cmd;
    sts_t sts;

    bpnc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    bpnc_dp #(
        .MAX_NODES (MAX_NODES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .operation           (operation),
        .node_index          (node_index),
        .right_child         (right_child),
        .left_child          (left_child),
        .tip_value           (tip_value),
        .tip_variance        (tip_variance),
        .branch_length       (branch_length),
        .branch_rate         (branch_rate),
        .result_valid        (result_valid),
        .result_ready        (result_ready),
        .out_node            (out_node),
        .init_mean           (init_mean),
        .init_variance       (init_variance),
        .base_mean           (base_mean),
        .base_variance       (base_variance),
        .log_term            (log_term),
        .zero_variance_error (zero_variance_error)
    );

endmodule

>>> hdl/bpnc_check.sv
module bpnc_check
    import bpnc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               request_valid,
    input logic               request_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic [9:0]         out_node,
    input logic signed [31:0] init_mean,
    input logic [30:0]        init_variance,
    input logic [30:0]        base_variance,
    input logic signed [31:0] log_term,
    input logic               zero_variance_error
);

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && request_ready |=> !request_ready)
        else $error("request taken while busy");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(out_node)
            && $stable(log_term) && $stable(base_variance))
        else $error("stalled result changed");

    a_zero_sum_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_variance_error |-> init_mean == 32'sd0
            && init_variance == 31'd0 && log_term == 32'sd0)
        else $error("zero variance sum with nonzero fields");

    a_no_result_while_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && request_ready && !result_valid |=> !result_valid)
        else $error("result appeared one cycle after request");

endmodule

bind brownian_pruning_node_combine bpnc_check u_bpnc_check (.*);
